FILE: sv/sfvs_pkg.sv
// Shared types, constants and control store of the sampled frequent value summary.
`timescale 1ns / 1ps
`default_nettype none

package sfvs_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int DATA_W      = 32;
   localparam int SEED_W      = 31;
   localparam int MULT_W      = 15;
   localparam int PROD_W      = SEED_W + MULT_W;
   localparam int SCALE_W     = DATA_W + SLOT_W;
   localparam int ROUND_LIMIT = 256;
   localparam int ROUND_W     = $clog2(ROUND_LIMIT + 1);

   localparam logic [DATA_W-1:0] PROB_ONE = 32'h8000_0000;
   localparam logic [DATA_W-1:0] CNT_MAX  = 32'hffff_ffff;
   localparam logic [SEED_W-1:0] GEN_MOD  = 31'h7fff_ffff;
   localparam logic [SEED_W-1:0] SEED_RST = 31'd1;
   localparam logic [MULT_W-1:0] GEN_MULT = 15'd16807;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_DUMP  = 2'd2
   } op_type;

   typedef logic [4:0] pc_type;

   // control store addresses
   localparam pc_type PC_FETCH  = 5'd0;
   localparam pc_type PC_FIND   = 5'd1;
   localparam pc_type PC_FREE   = 5'd2;
   localparam pc_type PC_ROUND  = 5'd3;
   localparam pc_type PC_LOAD   = 5'd4;
   localparam pc_type PC_TMUL   = 5'd5;
   localparam pc_type PC_TKEEP  = 5'd6;
   localparam pc_type PC_STORE  = 5'd7;
   localparam pc_type PC_SCALE  = 5'd8;
   localparam pc_type PC_SMUL   = 5'd9;
   localparam pc_type PC_SFOLD  = 5'd10;
   localparam pc_type PC_TEST   = 5'd11;
   localparam pc_type PC_INC    = 5'd12;
   localparam pc_type PC_CLEAR  = 5'd13;
   localparam pc_type PC_DSTART = 5'd14;
   localparam pc_type PC_DCHECK = 5'd15;
   localparam pc_type PC_DSKIP  = 5'd16;
   localparam pc_type PC_EMIT   = 5'd17;
   localparam pc_type PC_DNEXT  = 5'd18;
   localparam pc_type PC_DEND   = 5'd19;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_FETCH,
      ACT_FIND,
      ACT_TAKE_FREE,
      ACT_THIN_START,
      ACT_LOAD,
      ACT_MUL,
      ACT_FOLD_THIN,
      ACT_STORE,
      ACT_SCALE,
      ACT_FOLD,
      ACT_INC,
      ACT_CLEAR,
      ACT_DUMP_START,
      ACT_EMIT,
      ACT_K_INC
   } act_type;

   typedef enum logic [1:0] {
      JMP_SEQ,
      JMP_BR,
      JMP_GOTO,
      JMP_DISPATCH
   } jump_type;

   typedef enum logic [3:0] {
      C_NONE,
      C_MATCH,
      C_FREE,
      C_ROUNDS_DONE,
      C_LEFT_ZERO,
      C_K_NOT_LAST,
      C_P_ONE,
      C_REJECT,
      C_DUMP_DONE,
      C_COUNT_ZERO,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type  act;
      jump_type jump;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   // microprogram; a branch falls through to the next step when its condition is false
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         PC_FETCH:  w = '{ACT_FETCH,      JMP_DISPATCH, C_NONE,        PC_FETCH};
         // add: match, else free slot, else thin and retry
         PC_FIND:   w = '{ACT_FIND,       JMP_BR,       C_MATCH,       PC_SMUL};
         PC_FREE:   w = '{ACT_TAKE_FREE,  JMP_BR,       C_FREE,        PC_SMUL};
         PC_ROUND:  w = '{ACT_THIN_START, JMP_BR,       C_ROUNDS_DONE, PC_FETCH};
         PC_LOAD:   w = '{ACT_LOAD,       JMP_SEQ,      C_NONE,        PC_FETCH};
         PC_TMUL:   w = '{ACT_MUL,        JMP_BR,       C_LEFT_ZERO,   PC_STORE};
         PC_TKEEP:  w = '{ACT_FOLD_THIN,  JMP_GOTO,     C_NONE,        PC_TMUL};
         PC_STORE:  w = '{ACT_STORE,      JMP_BR,       C_K_NOT_LAST,  PC_LOAD};
         PC_SCALE:  w = '{ACT_SCALE,      JMP_GOTO,     C_NONE,        PC_FREE};
         // sampled increment
         PC_SMUL:   w = '{ACT_MUL,        JMP_BR,       C_P_ONE,       PC_INC};
         PC_SFOLD:  w = '{ACT_FOLD,       JMP_SEQ,      C_NONE,        PC_FETCH};
         PC_TEST:   w = '{ACT_NOP,        JMP_BR,       C_REJECT,      PC_FETCH};
         PC_INC:    w = '{ACT_INC,        JMP_GOTO,     C_NONE,        PC_FETCH};
         PC_CLEAR:  w = '{ACT_CLEAR,      JMP_GOTO,     C_NONE,        PC_FETCH};
         // dump walk
         PC_DSTART: w = '{ACT_DUMP_START, JMP_SEQ,      C_NONE,        PC_FETCH};
         PC_DCHECK: w = '{ACT_NOP,        JMP_BR,       C_DUMP_DONE,   PC_FETCH};
         PC_DSKIP:  w = '{ACT_NOP,        JMP_BR,       C_COUNT_ZERO,  PC_DNEXT};
         PC_EMIT:   w = '{ACT_EMIT,       JMP_BR,       C_OUT_BUSY,    PC_EMIT};
         PC_DNEXT:  w = '{ACT_K_INC,      JMP_BR,       C_K_NOT_LAST,  PC_DCHECK};
         PC_DEND:   w = '{ACT_NOP,        JMP_GOTO,     C_NONE,        PC_FETCH};
         default:   w = '{ACT_NOP,        JMP_GOTO,     C_NONE,        PC_FETCH};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: sv/sampled_frequent_value_summary.sv
// Top level: microcoded sampled frequent value summary with 8 value/count slots.
//
// req_ channel takes one command beat: op (add, clear, dump) and sample_value.
// rsp_ channel returns one beat per nonzero slot on a dump, last set on the final one.
// csr_wr_en/csr_wr_data load the generator seed; it takes effect at the next clear.
// One beat on req_ is accepted, then the sequencer runs the op:
//   add, matching slot, probability one      : increment the count
//   add into a free slot, probability one    : take the slot, then increment
//   add with a sampling draw                 : increment only if the draw is kept
//   clear                                    : empty the slots, load the seed
//   dump                                     : walk the slots, one beat per nonzero count
// A full table triggers thinning: one generator draw per unit of count (multiply
// then fold), slot by slot, up to 256 rounds; req_stall stays high.
// Reset (synchronous) empties the slots, sets probability to one and the seed to 1.
// A dump beat waits in the output register while rsp_stall is high; the walk
// holds until it is taken, and one beat may wait while the next command is fetched.
`timescale 1ns / 1ps
`default_nettype none

module sampled_frequent_value_summary (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_op,
   input  wire logic [sfvs_pkg::DATA_W-1:0]       req_sample_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [2:0]                             rsp_slot_index,
   output logic [sfvs_pkg::DATA_W-1:0]            rsp_slot_value,
   output logic [sfvs_pkg::DATA_W-1:0]            rsp_slot_count,
   output logic [sfvs_pkg::DATA_W-1:0]            rsp_keep_probability,
   output logic                                   rsp_last,
   input  wire logic                              csr_wr_en,
   input  wire logic [sfvs_pkg::SEED_W-1:0]       csr_wr_data
);

   localparam int SLOTS   = sfvs_pkg::SLOTS;
   localparam int SLOT_W  = sfvs_pkg::SLOT_W;
   localparam int DATA_W  = sfvs_pkg::DATA_W;
   localparam int SEED_W  = sfvs_pkg::SEED_W;
   localparam int PROD_W  = sfvs_pkg::PROD_W;
   localparam int SCALE_W = sfvs_pkg::SCALE_W;
   localparam int ROUND_W = sfvs_pkg::ROUND_W;

   sfvs_pkg::ctrl_word_type ctrl;

   sfvs_pkg::pc_type           pc_ff, pc_in;
   logic [DATA_W-1:0]          value_ff, value_in;
   logic [SLOT_W-1:0]          k_ff, k_in;
   logic [ROUND_W-1:0]         rounds_ff, rounds_in;
   logic [DATA_W-1:0]          left_ff, left_in;
   logic [DATA_W-1:0]          kept_ff, kept_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic                       deg_ff, deg_in;
   logic [SEED_W-1:0]          gen_ff, gen_in;
   logic [DATA_W-1:0]          prob_ff, prob_in;
   logic [SEED_W-1:0]          seed_ff, seed_in;
   logic [DATA_W-1:0]          vals_ff [SLOTS];
   logic [DATA_W-1:0]          vals_in [SLOTS];
   logic [DATA_W-1:0]          cnts_ff [SLOTS];
   logic [DATA_W-1:0]          cnts_in [SLOTS];
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [2:0]                 rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]          rsp_value_ff, rsp_value_in;
   logic [DATA_W-1:0]          rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0]          rsp_prob_ff, rsp_prob_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_accept;
   logic                       out_busy;
   logic [SLOTS-1:0]           match_vec, zero_vec, from_k_vec, after_k_vec;
   logic [SLOT_W-1:0]          match_idx, free_idx;
   logic                       cond_true;
   logic [DATA_W-1:0]          fold_sum;
   logic [SEED_W-1:0]          fold_val;
   logic [DATA_W-1:0]          prob_scaled;
   logic [SCALE_W-1:0]         prob_prod;
   logic [DATA_W-1:0]          thr;
   logic                       reject;
   logic                       rounds_done;

   assign ctrl       = sfvs_pkg::ucode_rom(pc_ff);
   assign req_stall  = (ctrl.act != sfvs_pkg::ACT_FETCH);
   assign req_accept = req_valid && !req_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot_index       = rsp_index_ff;
   assign rsp_slot_value       = rsp_value_ff;
   assign rsp_slot_count       = rsp_count_ff;
   assign rsp_keep_probability = rsp_prob_ff;
   assign rsp_last             = rsp_last_ff;

   // slot compares, all in parallel; lowest index wins
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i]   = (vals_ff[i] == value_ff);
         zero_vec[i]    = (cnts_ff[i] == '0);
         from_k_vec[i]  = !zero_vec[i] && (SLOT_W'(i) >= k_ff);
         after_k_vec[i] = !zero_vec[i] && (SLOT_W'(i) > k_ff);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = SLOT_W'(i);
         end
         if (zero_vec[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   // generator fold: x mod (2^31 - 1) from the registered product
   always_comb begin
      fold_sum = {1'b0, prod_ff[SEED_W-1:0]} + DATA_W'(prod_ff[PROD_W-1:SEED_W]);
      if (fold_sum >= {1'b0, sfvs_pkg::GEN_MOD}) begin
         fold_sum = fold_sum - {1'b0, sfvs_pkg::GEN_MOD};
      end
      // seeds 0 and 2^31-1 lock the generator at 2^31-1
      fold_val = deg_ff ? sfvs_pkg::GEN_MOD : fold_sum[SEED_W-1:0];
   end

   always_comb begin
      prob_prod   = SCALE_W'(prob_ff) * SCALE_W'(SLOTS - 1);
      prob_scaled = DATA_W'(prob_prod / SCALE_W'(SLOTS));
      // floor(p * (2^31 - 1) / 2^31) is p - 1 for 0 < p < one
      thr         = (prob_ff == '0) ? '0 : prob_ff - DATA_W'(1);
      reject      = ({1'b0, gen_ff} > thr);
      rounds_done = (rounds_ff == ROUND_W'(sfvs_pkg::ROUND_LIMIT));
   end

   always_comb begin
      case (ctrl.cond)
         sfvs_pkg::C_NONE:        cond_true = 1'b0;
         sfvs_pkg::C_MATCH:       cond_true = |match_vec;
         sfvs_pkg::C_FREE:        cond_true = |zero_vec;
         sfvs_pkg::C_ROUNDS_DONE: cond_true = rounds_done;
         sfvs_pkg::C_LEFT_ZERO:   cond_true = (left_ff == '0);
         sfvs_pkg::C_K_NOT_LAST:  cond_true = (k_ff != SLOT_W'(SLOTS - 1));
         sfvs_pkg::C_P_ONE:       cond_true = (prob_ff == sfvs_pkg::PROB_ONE);
         sfvs_pkg::C_REJECT:      cond_true = reject;
         sfvs_pkg::C_DUMP_DONE:   cond_true = !(|from_k_vec);
         sfvs_pkg::C_COUNT_ZERO:  cond_true = (cnts_ff[k_ff] == '0);
         sfvs_pkg::C_OUT_BUSY:    cond_true = out_busy;
         default:                 cond_true = 1'b0;
      endcase
   end

   // step sequencer
   always_comb begin
      case (ctrl.jump)
         sfvs_pkg::JMP_SEQ:  pc_in = pc_ff + 5'd1;
         sfvs_pkg::JMP_BR:   pc_in = cond_true ? ctrl.target : pc_ff + 5'd1;
         sfvs_pkg::JMP_GOTO: pc_in = ctrl.target;
         sfvs_pkg::JMP_DISPATCH: begin
            pc_in = sfvs_pkg::PC_FETCH;
            if (req_accept) begin
               case (req_op)
                  sfvs_pkg::OP_ADD:   pc_in = sfvs_pkg::PC_FIND;
                  sfvs_pkg::OP_CLEAR: pc_in = sfvs_pkg::PC_CLEAR;
                  sfvs_pkg::OP_DUMP:  pc_in = sfvs_pkg::PC_DSTART;
                  default:            pc_in = sfvs_pkg::PC_FETCH;
               endcase
            end
         end
         default: pc_in = sfvs_pkg::PC_FETCH;
      endcase
   end

   // datapath driven by the control word
   always_comb begin
      value_in     = value_ff;
      k_in         = k_ff;
      rounds_in    = rounds_ff;
      left_in      = left_ff;
      kept_in      = kept_ff;
      prod_in      = prod_ff;
      deg_in       = deg_ff;
      gen_in       = gen_ff;
      prob_in      = prob_ff;
      vals_in      = vals_ff;
      cnts_in      = cnts_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_last_in  = rsp_last_ff;

      case (ctrl.act)
         sfvs_pkg::ACT_FETCH: begin
            if (req_accept) begin
               value_in = req_sample_value;
            end
         end
         sfvs_pkg::ACT_FIND: begin
            rounds_in = '0;
            if (|match_vec) begin
               k_in = match_idx;
            end
         end
         sfvs_pkg::ACT_TAKE_FREE: begin
            if (|zero_vec) begin
               vals_in[free_idx] = value_ff;
               k_in              = free_idx;
            end
         end
         sfvs_pkg::ACT_THIN_START: begin
            k_in = '0;
            if (!rounds_done) begin
               rounds_in = rounds_ff + ROUND_W'(1);
            end
         end
         sfvs_pkg::ACT_LOAD: begin
            left_in = cnts_ff[k_ff];
            kept_in = '0;
         end
         sfvs_pkg::ACT_MUL: begin
            prod_in = PROD_W'(gen_ff) * PROD_W'(sfvs_pkg::GEN_MULT);
            deg_in  = (gen_ff == '0) || (gen_ff == sfvs_pkg::GEN_MOD);
         end
         sfvs_pkg::ACT_FOLD_THIN: begin
            gen_in  = fold_val;
            left_in = left_ff - DATA_W'(1);
            if ((fold_val % SEED_W'(SLOTS)) != '0) begin
               kept_in = kept_ff + DATA_W'(1);
            end
         end
         sfvs_pkg::ACT_STORE: begin
            cnts_in[k_ff] = kept_ff;
            k_in          = k_ff + SLOT_W'(1);
         end
         sfvs_pkg::ACT_SCALE: begin
            prob_in = prob_scaled;
         end
         sfvs_pkg::ACT_FOLD: begin
            gen_in = fold_val;
         end
         sfvs_pkg::ACT_INC: begin
            if (cnts_ff[k_ff] != sfvs_pkg::CNT_MAX) begin
               cnts_in[k_ff] = cnts_ff[k_ff] + DATA_W'(1);
            end
         end
         sfvs_pkg::ACT_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               vals_in[i] = '0;
               cnts_in[i] = '0;
            end
            prob_in = sfvs_pkg::PROB_ONE;
            gen_in  = seed_ff;
         end
         sfvs_pkg::ACT_DUMP_START: begin
            k_in = '0;
         end
         sfvs_pkg::ACT_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 3'(k_ff);
               rsp_value_in = vals_ff[k_ff];
               rsp_count_in = cnts_ff[k_ff];
               rsp_prob_in  = prob_ff;
               rsp_last_in  = !(|after_k_vec);
            end
         end
         sfvs_pkg::ACT_K_INC: begin
            k_in = k_ff + SLOT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= sfvs_pkg::PC_FETCH;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= sfvs_pkg::SEED_RST;
         gen_ff       <= sfvs_pkg::SEED_RST;
         prob_ff      <= sfvs_pkg::PROB_ONE;
         for (int i = 0; i < SLOTS; i++) begin
            vals_ff[i] <= '0;
            cnts_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
         prob_ff      <= prob_in;
         vals_ff      <= vals_in;
         cnts_ff      <= cnts_in;
      end
   end

   // scratch and result payload, no reset needed
   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      k_ff         <= k_in;
      rounds_ff    <= rounds_in;
      left_ff      <= left_in;
      kept_ff      <= kept_in;
      prod_ff      <= prod_in;
      deg_ff       <= deg_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

FILE: bench/sampled_frequent_value_summary_test.sv
// Self-checking bench for the sampled frequent value summary: command stream, slot dump checks.
`timescale 1ns / 1ps

module sampled_frequent_value_summary_test;

   localparam int SLOTS       = sfvs_pkg::SLOTS;
   localparam int DATA_W      = sfvs_pkg::DATA_W;
   localparam int SEED_W      = sfvs_pkg::SEED_W;
   localparam int ROUND_LIMIT = sfvs_pkg::ROUND_LIMIT;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int MAX_REPORTS = 8;
   localparam longint SCHRAGE_Q = 127773;
   localparam longint SCHRAGE_R = 2836;
   localparam int WATCHDOG_CYCLES = 200000;
   localparam int SETTLE_CAP = 60000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [2:0]        index;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] prob;
      logic              last;
   } slot_report_type;

   class summary_board;
      logic [DATA_W-1:0] held_value [SLOTS];
      logic [DATA_W-1:0] held_count [SLOTS];
      logic [DATA_W-1:0] keep_prob;
      logic [SEED_W-1:0] gen_state;
      logic [SEED_W-1:0] seed;
      slot_report_type   expected_reports [$];
      int                errors;
      int                work_cycles;   // rough busy time of commands since the last dump

      function new();
         seed = sfvs_pkg::SEED_RST;
         errors = 0;
         work_cycles = 0;
         clear_table();
      endfunction

      function void clear_table();
         foreach (held_value[k]) begin
            held_value[k] = '0;
            held_count[k] = '0;
         end
         keep_prob = sfvs_pkg::PROB_ONE;
         gen_state = seed & sfvs_pkg::GEN_MOD;
      endfunction

      // minimal-standard generator, Schrage split
      function logic [SEED_W-1:0] next_random();
         longint s, hi, lo, x;
         s = longint'(gen_state);
         hi = s / SCHRAGE_Q;
         lo = s % SCHRAGE_Q;
         x = longint'(sfvs_pkg::GEN_MULT) * lo - SCHRAGE_R * hi;
         if (x <= 0) x += longint'(sfvs_pkg::GEN_MOD);
         gen_state = x[SEED_W-1:0];
         return gen_state;
      endfunction

      function void add_sample(logic [DATA_W-1:0] v);
         int slot, rounds, k;
         logic [DATA_W-1:0] left, kept;
         logic [63:0] thr;
         slot = -1;
         rounds = 0;
         work_cycles += 8;
         for (k = 0; k < SLOTS; k++)
            if (slot < 0 && held_value[k] == v) slot = k;
         while (slot < 0) begin
            for (k = 0; k < SLOTS; k++)
               if (slot < 0 && held_count[k] == 0) begin
                  held_value[k] = v;
                  slot = k;
               end
            if (slot < 0) begin
               if (rounds >= ROUND_LIMIT) return;
               // table full: keep each unit with probability 7/8
               for (k = 0; k < SLOTS; k++) begin
                  work_cycles += 2 * int'(held_count[k]) + 6;
                  left = held_count[k];
                  kept = '0;
                  while (left != 0) begin
                     left--;
                     if (next_random() % SLOTS != 0) kept++;
                  end
                  held_count[k] = kept;
               end
               keep_prob = DATA_W'((64'(keep_prob) * (SLOTS - 1)) / SLOTS);
               rounds++;
            end
         end
         if (keep_prob != sfvs_pkg::PROB_ONE) begin
            thr = (64'(keep_prob) * 64'(sfvs_pkg::GEN_MOD)) >> 31;
            if (64'(next_random()) > thr) return;
         end
         if (held_count[slot] != sfvs_pkg::CNT_MAX) held_count[slot]++;
      endfunction

      function void note_command(logic [1:0] op, logic [DATA_W-1:0] v);
         slot_report_type batch [$];
         slot_report_type r;
         int k;
         if (op == sfvs_pkg::OP_ADD) begin
            add_sample(v);
         end else if (op == sfvs_pkg::OP_CLEAR) begin
            clear_table();
            work_cycles += 4;
         end else if (op == sfvs_pkg::OP_DUMP) begin
            work_cycles = 4 * SLOTS + 8;
            for (k = 0; k < SLOTS; k++)
               if (held_count[k] != 0 && batch.size() < MAX_REPORTS) begin
                  r.index = 3'(k);
                  r.value = held_value[k];
                  r.count = held_count[k];
                  r.prob  = keep_prob;
                  r.last  = 1'b0;
                  batch.push_back(r);
               end
            for (k = 0; k < batch.size(); k++) begin
               r = batch[k];
               r.last = (k == batch.size() - 1);
               expected_reports.push_back(r);
            end
         end
      endfunction

      function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_slot(logic [2:0] idx, logic [DATA_W-1:0] val, logic [DATA_W-1:0] cnt,
                               logic [DATA_W-1:0] prob, logic lst);
         slot_report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual slot %0d value %h count %h",
                     $time, idx, val, cnt);
            errors++;
            return;
         end
         want = expected_reports.pop_front();
         compare_field("slot_index", 32'(want.index), 32'(idx));
         compare_field("slot_value", want.value, val);
         compare_field("slot_count", want.count, cnt);
         compare_field("keep_probability", want.prob, prob);
         compare_field("last", 32'(want.last), 32'(lst));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_op = sfvs_pkg::OP_ADD;
   logic [DATA_W-1:0] req_sample_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_slot_index;
   logic [DATA_W-1:0] rsp_slot_value;
   logic [DATA_W-1:0] rsp_slot_count;
   logic [DATA_W-1:0] rsp_keep_probability;
   logic              rsp_last;
   logic              csr_wr_en = 1'b0;
   logic [SEED_W-1:0] csr_wr_data = '0;

   summary_board board = new();
   bit no_idle = 1'b0;
   int hold_requests = 0;

   always #2 clock = ~clock;

   sampled_frequent_value_summary DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_sample_value     (req_sample_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_slot_index       (rsp_slot_index),
      .rsp_slot_value       (rsp_slot_value),
      .rsp_slot_count       (rsp_slot_count),
      .rsp_keep_probability (rsp_keep_probability),
      .rsp_last             (rsp_last),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // valid stays high after a beat so back-to-back beats need no second assignment
   task automatic send_beat(input logic [1:0] op, input logic [DATA_W-1:0] v);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_sample_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(op, v);
   endtask

   // wait for every dump beat, then for the tail of any add or clear still running
   task automatic settle();
      int w;
      req_valid <= 1'b0;
      while (board.expected_reports.size() != 0) @(posedge clock);
      w = 2 * board.work_cycles + 16;
      repeat ((w > SETTLE_CAP) ? SETTLE_CAP : w) @(posedge clock);
      board.work_cycles = 0;
   endtask

   task automatic write_seed(input logic [SEED_W-1:0] s);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.seed = s;
   endtask

   task automatic random_phase(input logic [SEED_W-1:0] s, input int items, input int pool_size,
                               input int hold_at, input int pause_at);
      logic [DATA_W-1:0] pool [16];
      logic [DATA_W-1:0] v;
      logic [1:0] op;
      int pick, n;
      foreach (pool[i]) pool[i] = $urandom();
      write_seed(s);
      send_beat(sfvs_pkg::OP_CLEAR, $urandom());   // seed is taken on clear
      for (n = 1; n < items; n++) begin
         if (n == pause_at) settle();
         if (n == hold_at) begin
            hold_requests++;
            repeat (5) send_beat(sfvs_pkg::OP_DUMP, $urandom());
         end
         pick = $urandom_range(0, 99);
         v = ($urandom_range(0, 15) == 0) ? $urandom() : pool[$urandom_range(0, pool_size - 1)];
         if (pick < 82) op = sfvs_pkg::OP_ADD;
         else if (pick < 94) op = sfvs_pkg::OP_DUMP;
         else if (pick < 98) op = sfvs_pkg::OP_CLEAR;
         else op = OP_UNUSED;
         send_beat(op, v);
      end
   endtask

   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_slot(rsp_slot_index, rsp_slot_value, rsp_slot_count,
                             rsp_keep_probability, rsp_last);
         if (hold_requests != 0) begin
            hold_requests--;
            gap = LONG_HOLD;
         end else if (gap == 0 && !no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            gap--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [DATA_W-1:0] fill [6];
      int k;
      fill = '{32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001,
               32'h8000_0000, 32'h0000_ffff, 32'hffff_0000};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_beat(sfvs_pkg::OP_DUMP, 32'h0);             // empty summary
      send_beat(sfvs_pkg::OP_ADD, 32'h0);              // matches slot 0 while its count is zero
      send_beat(sfvs_pkg::OP_ADD, 32'hffff_ffff);
      foreach (fill[i]) send_beat(sfvs_pkg::OP_ADD, fill[i]);
      send_beat(sfvs_pkg::OP_ADD, 32'hffff_ffff);
      send_beat(sfvs_pkg::OP_DUMP, 32'hffff_ffff);     // all eight slots
      send_beat(sfvs_pkg::OP_ADD, 32'h1234_5678);      // full table, thinning
      send_beat(sfvs_pkg::OP_ADD, 32'h0);
      send_beat(sfvs_pkg::OP_DUMP, 32'h0);
      send_beat(OP_UNUSED, 32'hdead_beef);             // ignored
      send_beat(sfvs_pkg::OP_CLEAR, 32'h0);
      send_beat(sfvs_pkg::OP_DUMP, 32'h0);

      // stuck generator: thinning never frees a slot, sample dropped after the round limit
      write_seed('0);
      send_beat(sfvs_pkg::OP_CLEAR, 32'h0);
      for (k = 1; k <= SLOTS; k++) send_beat(sfvs_pkg::OP_ADD, 32'(k));
      send_beat(sfvs_pkg::OP_ADD, 32'(SLOTS + 1));
      send_beat(sfvs_pkg::OP_ADD, 32'h1);               // draw always rejects now
      send_beat(sfvs_pkg::OP_DUMP, 32'h0);

      random_phase(31'h7fff_fffe, 26, 12, 0, 0);
      random_phase(sfvs_pkg::GEN_MOD, 20, 9, 0, 0);
      random_phase(SEED_W'($urandom_range(1, 32'h7fff_fffe)), 50, 16, 25, 0);
      random_phase(sfvs_pkg::SEED_RST, 45, 10, 0, 20);
      no_idle = 1'b1;
      random_phase(SEED_W'($urandom_range(1, 32'h7fff_fffe)), 40, 12, 0, 0);
      settle();

      if (board.errors == 0 && board.expected_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
